[design/apsl_pkg.sv]
// ----------------------------------------------------------------------------
// apsl_pkg
// Shared constants for the Annex B parameter-set locator.
// ----------------------------------------------------------------------------
package apsl_pkg;

	localparam int unsigned MAX_UNIT_BYTES_DEF = 65536;

	localparam logic [7:0] TYPE_MASK   = 8'h1f;
	localparam logic [4:0] TYPE_UNSPEC = 5'd0;
	localparam logic [4:0] TYPE_SPS    = 5'd7;
	localparam logic [4:0] TYPE_PPS    = 5'd8;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] BYTE_ONE    = 8'h01;

endpackage

[design/annexb_parameter_set_locator.sv]
// ----------------------------------------------------------------------------
// annexb_parameter_set_locator
// Scans one H.264 Annex B access unit per frame and reports the byte span that
// holds the first SPS and the PPS after it.
// ----------------------------------------------------------------------------
// One byte is taken per cycle with no gaps needed. Each byte goes into an input
// register, and the next cycle updates the start code window and span state in
// a single pass. The byte flagged tlast yields one result item in the output
// register once it leaves the input register; the input keeps flowing while that
// result waits, and stalls only if a second frame end arrives before the first
// result is taken. Bytes at offsets MAX_UNIT_BYTES and beyond are neither counted
// nor scanned, and overflow is set in the result.
module annexb_parameter_set_locator #(
	parameter int unsigned MAX_UNIT_BYTES = apsl_pkg::MAX_UNIT_BYTES_DEF,
	localparam int unsigned OFF_W  = $clog2(MAX_UNIT_BYTES + 1),
	localparam int unsigned DATA_W = ((2 * OFF_W + 2 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // data_byte
	input  logic              s_tlast,  // last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata   // found, config_start, config_end, overflow, zero pad
);

	localparam logic [OFF_W-1:0] MAX_POS = OFF_W'(MAX_UNIT_BYTES);
	localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);
	localparam logic [OFF_W-1:0] OFF_TWO = OFF_W'(2);
	localparam logic [OFF_W-1:0] OFF_THR = OFF_W'(3);

	typedef struct packed {
		logic             sps_seen;
		logic             pps_seen;
		logic             closed;
		logic [OFF_W-1:0] sps_off;
		logic [OFF_W-1:0] span_end;
		logic [OFF_W-1:0] pend;
	} span_t;

	function automatic span_t apply_type(span_t st, logic [4:0] ty);
		span_t r;
		r = st;
		if (!st.closed) begin
			if (ty == apsl_pkg::TYPE_SPS && !st.sps_seen) begin
				r.sps_seen = 1'b1;
				r.sps_off  = st.pend;
			end else if (ty == apsl_pkg::TYPE_PPS && st.sps_seen && !st.pps_seen) begin
				r.pps_seen = 1'b1;
				r.span_end = '0;
			end else if (ty != apsl_pkg::TYPE_SPS && ty != apsl_pkg::TYPE_PPS &&
			             st.pps_seen) begin
				r.span_end = st.pend;
				r.closed   = 1'b1;
			end
		end
		return r;
	endfunction

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	// scan state
	span_t            st_q, st_n;
	logic             hp_q, hp_n;
	logic [23:0]      win_q, win_n;
	logic [OFF_W-1:0] pos_q, pos_n;
	logic             over_q, over_n;

	logic             sc_fire;
	logic [OFF_W-1:0] sc_off;
	logic             ty_fire;
	logic [4:0]       ty_val;
	logic [7:0]       b0, b1, b2;
	logic             found_d;
	logic [DATA_W-1:0] tdata_d;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;

	assign advance  = valid_s1 && (!last_s1 || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		st_n    = st_q;
		hp_n    = hp_q;
		win_n   = win_q;
		pos_n   = pos_q;
		over_n  = over_q;
		sc_fire = 1'b0;
		sc_off  = '0;
		ty_fire = 1'b0;
		ty_val  = '0;
		b0      = win_q[7:0];
		b1      = win_q[15:8];
		b2      = win_q[23:16];

		if (pos_q < MAX_POS) begin
			pos_n = pos_q + OFF_ONE;
			if (!st_q.closed) begin
				if (hp_q) begin
					if (b0 == apsl_pkg::BYTE_ONE) begin
						if (byte_s1 != apsl_pkg::BYTE_ZERO) begin
							ty_fire = 1'b1;
							ty_val  = 5'(byte_s1 & apsl_pkg::TYPE_MASK);
						end
					end else if (b1 == apsl_pkg::BYTE_ONE) begin
						ty_fire = byte_s1 != apsl_pkg::BYTE_ZERO;
					end else if (b2 == apsl_pkg::BYTE_ONE) begin
						if (byte_s1 == apsl_pkg::BYTE_ONE) begin
							sc_fire = 1'b1;
							sc_off  = pos_q - OFF_TWO;
						end else begin
							ty_fire = byte_s1 != apsl_pkg::BYTE_ZERO;
						end
					end else begin
						if (byte_s1 == apsl_pkg::BYTE_ONE) begin
							sc_fire = 1'b1;
							sc_off  = pos_q - OFF_THR;
						end else begin
							ty_fire = 1'b1;
						end
					end
				end else if (byte_s1 == apsl_pkg::BYTE_ONE && pos_q >= OFF_TWO &&
				             b0 == apsl_pkg::BYTE_ZERO && b1 == apsl_pkg::BYTE_ZERO) begin
					sc_fire = 1'b1;
					sc_off  = (pos_q >= OFF_THR && b2 == apsl_pkg::BYTE_ZERO) ?
					          pos_q - OFF_THR : pos_q - OFF_TWO;
				end
				win_n = {win_q[15:0], byte_s1};
			end
		end else begin
			over_n = 1'b1;
		end

		if (sc_fire) begin
			if (st_n.pps_seen && st_n.span_end == '0) begin
				st_n.span_end = sc_off;
			end
			st_n.pend = sc_off;
			hp_n      = 1'b1;
		end
		if (ty_fire) begin
			hp_n = 1'b0;
			st_n = apply_type(st_n, ty_val);
		end

		// frame end: a held zero header becomes a type 0 NAL, open PPS ends here
		if (last_s1 && !st_n.closed) begin
			if (hp_n && win_n[7:0] != apsl_pkg::BYTE_ONE) begin
				hp_n = 1'b0;
				st_n = apply_type(st_n, apsl_pkg::TYPE_UNSPEC);
			end
			if (!st_n.closed && st_n.pps_seen && st_n.span_end == '0) begin
				st_n.span_end = pos_n;
			end
		end

		found_d = st_n.sps_seen && st_n.pps_seen && (st_n.span_end > st_n.sps_off);
		tdata_d = DATA_W'({over_n,
		                   found_d ? st_n.span_end : {OFF_W{1'b0}},
		                   found_d ? st_n.sps_off : {OFF_W{1'b0}},
		                   found_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			hp_q   <= 1'b0;
			win_q  <= '0;
			pos_q  <= '0;
			over_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				st_q   <= '0;
				hp_q   <= 1'b0;
				win_q  <= '0;
				pos_q  <= '0;
				over_q <= 1'b0;
			end else begin
				st_q   <= st_n;
				hp_q   <= hp_n;
				win_q  <= win_n;
				pos_q  <= pos_n;
				over_q <= over_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_tdata_q <= tdata_d;
		end
	end

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(advance && last_s1))
		else $error("result item without a frame end");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[0]) |->
		(m_tdata_q[2*OFF_W:OFF_W+1] > m_tdata_q[OFF_W:1]))
		else $error("found span does not end after its start");

	a_empty_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tdata_q[0]) |-> (m_tdata_q[2*OFF_W:1] == '0))
		else $error("offsets reported without a found span");

	a_clear_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (pos_q == '0 && !st_q.sps_seen && !hp_q && !over_q))
		else $error("scan state not cleared after frame end");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= MAX_POS) && (!st_q.pps_seen || st_q.sps_seen))
		else $error("position beyond limit or PPS without SPS");

endmodule

[bench/tb_annexb_parameter_set_locator.sv]
// ----------------------------------------------------------------------------
// tb_annexb_parameter_set_locator
// Streams Annex B access units through the locator and checks the reported
// SPS/PPS span of every unit against a cycle-free prediction.
// Covers directed start-code corner cases, back-pressure and a large set of
// random units.
// ----------------------------------------------------------------------------
module tb_annexb_parameter_set_locator;

	localparam int unsigned UNIT_MAX    = apsl_pkg::MAX_UNIT_BYTES_DEF;
	localparam int unsigned OFF_W       = $clog2(UNIT_MAX + 1);
	localparam int unsigned DATA_W      = ((2 * OFF_W + 2 + 7) / 8) * 8;
	localparam int          CYCLE_LIMIT = 1500000;
	localparam int          RAND_ITEMS  = 1260;
	localparam int          CALM_ITEMS  = 180;
	localparam int          LONG_HOLD   = 250;
	localparam int          DRAIN_WAIT  = 8;

	localparam logic [4:0] NAL_UNSPEC = 5'd0;
	localparam logic [4:0] NAL_SLICE  = 5'd1;
	localparam logic [4:0] NAL_IDR    = 5'd5;
	localparam logic [4:0] NAL_SEI    = 5'd6;
	localparam logic [4:0] NAL_AUD    = 5'd9;
	localparam logic [7:0] BYTE_EMUL  = 8'h03;

	typedef struct {
		bit              found;
		bit [OFF_W-1:0]  cfg_start;
		bit [OFF_W-1:0]  cfg_end;
		bit              ovf;
	} span_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = 8'h00;  // data_byte
	logic              s_tlast  = 1'b0;   // last
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;           // found, config_start, config_end, overflow

	annexb_parameter_set_locator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// predicted scan state of the current unit
	bit [31:0]   win;
	int unsigned pos;
	int unsigned nal_start;
	bit          hdr_wait;
	int unsigned sps_at;
	bit          sps_hit;
	bit          pps_hit;
	bit          closed;
	int unsigned end_at;

	span_t       span_q[$];
	logic [7:0]  unit_bytes[$];

	int errs       = 0;
	int items_sent = 0;
	int n_units    = 0;
	int n_found    = 0;
	int n_over     = 0;
	int cycle_cnt  = 0;
	bit tx_calm    = 1'b0;
	bit rx_calm    = 1'b0;
	int hold_asked = 0;
	int hold_done  = 0;
	int rx_hold    = 0;

	function automatic void clear_unit();
		win       = '0;
		pos       = 0;
		nal_start = 0;
		hdr_wait  = 1'b0;
		sps_at    = 0;
		sps_hit   = 1'b0;
		pps_hit   = 1'b0;
		closed    = 1'b0;
		end_at    = 0;
	endfunction

	function automatic void nal_kind(input logic [4:0] t);
		if (closed)
			return;
		if (t == apsl_pkg::TYPE_SPS && !sps_hit) begin
			sps_hit = 1'b1;
			sps_at  = nal_start;
		end else if (t == apsl_pkg::TYPE_PPS && sps_hit && !pps_hit) begin
			pps_hit = 1'b1;
			end_at  = 0;
		end else if (t != apsl_pkg::TYPE_SPS && t != apsl_pkg::TYPE_PPS && pps_hit) begin
			end_at = nal_start;
			closed = 1'b1;
		end
	endfunction

	function automatic void mark_start(input int unsigned s);
		if (pps_hit && end_at == 0)
			end_at = s;
		nal_start = s;
		hdr_wait  = 1'b1;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input int unsigned p);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] hb;
		b0 = win[7:0];
		b1 = win[15:8];
		b2 = win[23:16];
		hb = b & apsl_pkg::TYPE_MASK;
		if (hdr_wait) begin
			if (b0 == apsl_pkg::BYTE_ONE) begin
				if (b != apsl_pkg::BYTE_ZERO) begin
					hdr_wait = 1'b0;
					nal_kind(hb[4:0]);
				end
			end else if (b1 == apsl_pkg::BYTE_ONE) begin
				if (b != apsl_pkg::BYTE_ZERO) begin
					hdr_wait = 1'b0;
					nal_kind(NAL_UNSPEC);
				end
			end else if (b2 == apsl_pkg::BYTE_ONE) begin
				if (b == apsl_pkg::BYTE_ONE) begin
					mark_start(p - 2);
				end else if (b != apsl_pkg::BYTE_ZERO) begin
					hdr_wait = 1'b0;
					nal_kind(NAL_UNSPEC);
				end
			end else begin
				if (b == apsl_pkg::BYTE_ONE) begin
					mark_start(p - 3);
				end else begin
					hdr_wait = 1'b0;
					nal_kind(NAL_UNSPEC);
				end
			end
		end else if (b == apsl_pkg::BYTE_ONE && p >= 2 && b0 == apsl_pkg::BYTE_ZERO &&
		             b1 == apsl_pkg::BYTE_ZERO) begin
			mark_start((p >= 3 && b2 == apsl_pkg::BYTE_ZERO) ? p - 3 : p - 2);
		end
		win = {win[23:0], b};
	endfunction

	// advance the prediction by one byte; returns 1 when the unit ends
	function automatic bit locate_step(input logic [7:0] b, input bit l, output span_t r);
		int unsigned unit_len;
		bit          over;
		r = '{default: '0};
		if (pos < UNIT_MAX) begin
			if (!closed)
				scan_byte(b, pos);
			pos++;
		end else begin
			pos = UNIT_MAX + 1;
		end
		if (!l)
			return 1'b0;
		over     = pos > UNIT_MAX;
		unit_len = over ? UNIT_MAX : pos;
		if (!closed) begin
			if (hdr_wait && win[7:0] != apsl_pkg::BYTE_ONE) begin
				hdr_wait = 1'b0;
				nal_kind(NAL_UNSPEC);
			end
			if (!closed && pps_hit && end_at == 0)
				end_at = unit_len;
		end
		r.found = sps_hit && pps_hit && end_at > sps_at;
		if (r.found) begin
			r.cfg_start = sps_at[OFF_W-1:0];
			r.cfg_end   = end_at[OFF_W-1:0];
		end
		r.ovf = over;
		clear_unit();
		return 1'b1;
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit l, input bit gappy);
		span_t r;
		if (gappy && !tx_calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (locate_step(b, l, r)) begin
			span_q.push_back(r);
			n_units++;
			if (r.found)
				n_found++;
			if (r.ovf)
				n_over++;
		end
	endtask

	task automatic send_unit(input bit gappy);
		int i;
		for (i = 0; i < unit_bytes.size(); i++)
			push_byte(unit_bytes[i], i == unit_bytes.size() - 1, gappy);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (span_q.size() != 0) @(posedge clk);
	endtask

	task automatic add_start_code(input bit four);
		if (four)
			unit_bytes.push_back(apsl_pkg::BYTE_ZERO);
		unit_bytes.push_back(apsl_pkg::BYTE_ZERO);
		unit_bytes.push_back(apsl_pkg::BYTE_ZERO);
		unit_bytes.push_back(apsl_pkg::BYTE_ONE);
	endtask

	function automatic logic [4:0] pick_type();
		case ($urandom_range(0, 9))
			0, 1:    return apsl_pkg::TYPE_SPS;
			2, 3:    return apsl_pkg::TYPE_PPS;
			4:       return NAL_IDR;
			5:       return NAL_SLICE;
			6:       return NAL_AUD;
			7:       return NAL_UNSPEC;
			8:       return NAL_SEI;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 9))
			0, 1:    return apsl_pkg::BYTE_ZERO;
			2:       return apsl_pkg::BYTE_ONE;
			3:       return BYTE_EMUL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_unit();
		int         k;
		int         n_nal;
		bit         ordered;
		logic [4:0] t;
		unit_bytes.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 20)) unit_bytes.push_back(payload_byte());
			return;
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 4)) unit_bytes.push_back(payload_byte());
		ordered = $urandom_range(0, 4) != 0;
		n_nal   = $urandom_range(1, 6);
		for (k = 0; k < n_nal; k++) begin
			add_start_code(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 11) == 0)
				continue;
			if (ordered && k == 0)
				t = apsl_pkg::TYPE_SPS;
			else if (ordered && k == 1)
				t = apsl_pkg::TYPE_PPS;
			else
				t = pick_type();
			if (t == NAL_UNSPEC && $urandom_range(0, 1))
				unit_bytes.push_back(apsl_pkg::BYTE_ZERO);
			else
				unit_bytes.push_back({3'($urandom_range(0, 7)), t});
			repeat ($urandom_range(0, 10)) unit_bytes.push_back(payload_byte());
		end
		if ($urandom_range(0, 5) == 0)
			add_start_code(1'b0);
	endtask

	task automatic test_directed();
		logic [7:0] unit_a[$] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'he7, 8'h00, 8'h00,
			8'h01, 8'he8, 8'h00, 8'h00, 8'h01, 8'hff};
		logic [7:0] unit_b[$] = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
		logic [7:0] unit_c[$] = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02,
			8'h00, 8'h00, 8'h01};
		unit_bytes = unit_a;
		send_unit(1'b0);
		unit_bytes = unit_b;
		send_unit(1'b1);
		unit_bytes = unit_c;
		send_unit(1'b1);
		wait_drained();
	endtask

	// receiver stalls long while short units keep coming
	task automatic test_backpressure();
		hold_asked++;
		repeat (30) begin
			unit_bytes.delete();
			repeat ($urandom_range(1, 3)) unit_bytes.push_back(payload_byte());
			send_unit(1'b0);
		end
		wait_drained();
	endtask

	task automatic test_random();
		int stop_at;
		stop_at = items_sent + RAND_ITEMS;
		while (items_sent < stop_at) begin
			if (stop_at - items_sent < CALM_ITEMS) begin
				tx_calm = 1'b1;
				rx_calm = 1'b1;
			end
			build_unit();
			send_unit($urandom_range(0, 3) != 0);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			rx_hold   = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
			rx_hold   = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		span_t exp;
		if (m_tvalid && m_tready) begin
			if (span_q.size() == 0) begin
				$error("result item with no access unit pending");
				errs++;
			end else begin
				exp = span_q.pop_front();
				if (m_tdata[0] !== exp.found) begin
					$error("found: expected %0d, got %0d", exp.found, m_tdata[0]);
					errs++;
				end
				if (m_tdata[OFF_W:1] !== exp.cfg_start) begin
					$error("config_start: expected %0d, got %0d", exp.cfg_start,
						m_tdata[OFF_W:1]);
					errs++;
				end
				if (m_tdata[2*OFF_W:OFF_W+1] !== exp.cfg_end) begin
					$error("config_end: expected %0d, got %0d", exp.cfg_end,
						m_tdata[2*OFF_W:OFF_W+1]);
					errs++;
				end
				if (m_tdata[2*OFF_W+1] !== exp.ovf) begin
					$error("overflow: expected %0d, got %0d", exp.ovf, m_tdata[2*OFF_W+1]);
					errs++;
				end
				if (m_tdata[DATA_W-1:2*OFF_W+2] !== '0) begin
					$error("pad: expected 0, got %0h", m_tdata[DATA_W-1:2*OFF_W+2]);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clear_unit();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (span_q.size() != 0) begin
			$error("%0d result items never arrived", span_q.size());
			errs++;
		end
		$display("%0d bytes in %0d access units checked", items_sent, n_units);
		$display("%0d units held a parameter-set span, %0d ran past the length limit",
			n_found, n_over);
		if (errs == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
